### rtl/ppi_pkg.sv
// Shared types and constants for the PPI port latch serial bridge.
// No dependencies; imported by the interfaces and all modules.
`default_nettype none
package ppi_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_BRIDGE_ACTIVE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RX_DECODE     = 2'd1;

  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_RX    = 2'd2;

  localparam logic [1:0] SEL_PORT_A  = 2'd0;
  localparam logic [1:0] SEL_PORT_B  = 2'd1;
  localparam logic [1:0] SEL_PORT_C  = 2'd2;
  localparam logic [1:0] SEL_CONTROL = 2'd3;

  localparam logic [7:0] TX_DATA_MASK = 8'h6F;
  localparam logic [7:0] TX_TAG_A     = 8'h80;
  localparam logic [7:0] TX_TAG_B     = 8'h90;
  localparam logic [7:0] TX_CW_MASK   = 8'h78;
  localparam logic [7:0] TX_TAG_CW    = 8'h40;
  localparam logic [7:0] TX_CW_LOW    = 8'h03;
  localparam logic [7:0] TX_BIT_MASK  = 8'h0F;
  localparam logic [7:0] TX_TAG_BIT   = 8'h10;
  localparam logic [7:0] RX_SEL_MASK  = 8'h90;
  localparam logic [7:0] RX_HI_MASK   = 8'hF0;
  localparam logic [7:0] RX_END_MARK  = 8'h30;
  localparam logic [7:0] BYTE_ONES    = 8'hFF;
  localparam logic [7:0] CW_RESET     = 8'h92;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] bus_addr;
    logic [7:0] bus_data;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       joy_valid;
    logic       joy_port;
    logic [7:0] joy_level;
    logic       end_mark_seen;
    logic [7:0] end_mark_byte;
  } out_word_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_word_t;

  typedef struct packed {
    logic bridge_active;
    logic rx_decode;
  } cfg_t;

  typedef struct packed {
    logic [7:0] latch_a;
    logic [7:0] latch_b;
    logic [7:0] latch_c;
    logic [7:0] control_word;
    logic [7:0] remote_a;
    logic [7:0] remote_b;
    logic [7:0] remote_c;
    logic [7:0] last_bit_command;
  } state_t;

  localparam state_t STATE_RESET = '{
    latch_a:          BYTE_ONES,
    latch_b:          BYTE_ONES,
    latch_c:          8'h00,
    control_word:     CW_RESET,
    remote_a:         BYTE_ONES,
    remote_b:         BYTE_ONES,
    remote_c:         8'h00,
    last_bit_command: BYTE_ONES
  };

endpackage
`default_nettype wire

### rtl/ppi_if.sv
// Valid/ready channel interfaces: input words, result words, config writes.
// Depends on ppi_pkg for the payload types.
`default_nettype none
interface ppi_in_if;
  import ppi_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ppi_out_if;
  import ppi_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ppi_cfg_if;
  import ppi_pkg::*;
  logic      valid;
  logic      ready;
  cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/ppi_step.sv
// Per-word decode: bus read mux, write latching and serial translation,
// received byte decode. Pure combinational; depends on ppi_pkg.
`default_nettype none
module ppi_step (
  input  ppi_pkg::cfg_t      cfg,
  input  ppi_pkg::state_t    state,
  input  ppi_pkg::in_word_t  word,
  output ppi_pkg::state_t    state_next,
  output ppi_pkg::out_word_t result
);
  import ppi_pkg::*;

  logic [1:0] sel;
  logic [7:0] d;
  logic [7:0] b;
  logic [7:0] bit_mask;
  logic [7:0] tx;
  logic       send;

  assign sel = word.bus_addr[2:1];
  assign d = word.bus_data;
  assign b = word.rx_byte;
  assign bit_mask = 8'h01 << d[3:1];

  always_comb begin
    state_next = state;
    result = '0;
    tx = '0;
    send = 1'b0;
    unique case (word.mode)
      MODE_READ: begin
        if (!word.bus_addr[0]) begin
          result.read_data = BYTE_ONES;
        end else begin
          unique case (sel)
            SEL_PORT_A: result.read_data = cfg.bridge_active ? state.remote_a : state.latch_a;
            SEL_PORT_B: result.read_data = cfg.bridge_active ? state.remote_b : state.latch_b;
            SEL_PORT_C: result.read_data = cfg.bridge_active ?
                          (state.remote_c | (state.latch_c & TX_BIT_MASK)) : state.latch_c;
            SEL_CONTROL: result.read_data = BYTE_ONES;
          endcase
        end
      end
      MODE_WRITE: begin
        if (word.bus_addr[0]) begin
          send = cfg.bridge_active;
          unique case (sel)
            SEL_PORT_A: begin
              tx = (d & TX_DATA_MASK) | TX_TAG_A;
              state_next.latch_a = d;
            end
            SEL_PORT_B: begin
              tx = (d & TX_DATA_MASK) | TX_TAG_B;
              state_next.latch_b = d;
            end
            SEL_PORT_C: begin
              tx = {4'h0, d[7:4]};
              state_next.latch_c = d;
            end
            SEL_CONTROL: begin
              if (d[7]) begin
                tx = ((d & TX_CW_MASK) >> 1) | (d & TX_CW_LOW) | TX_TAG_CW;
                state_next.control_word = d;
              end else begin
                if (cfg.bridge_active) begin
                  if (d == state.last_bit_command) begin
                    send = 1'b0;
                  end else begin
                    state_next.last_bit_command = d;
                    tx = (d & TX_BIT_MASK) | TX_TAG_BIT;
                  end
                end
                if (d[0]) begin
                  state_next.latch_c = state.latch_c | bit_mask;
                end else begin
                  state_next.latch_c = state.latch_c & ~bit_mask;
                end
              end
            end
          endcase
          result.tx_valid = send;
          result.tx_byte = send ? tx : 8'h00;
        end
      end
      MODE_RX: begin
        if ((b & RX_HI_MASK) == RX_END_MARK) begin
          result.end_mark_seen = 1'b1;
          result.end_mark_byte = b;
        end
        if (cfg.rx_decode) begin
          priority if ((b & RX_SEL_MASK) == TX_TAG_A) begin
            state_next.remote_a = b | RX_SEL_MASK;
            result.joy_valid = 1'b1;
            result.joy_port = 1'b0;
            result.joy_level = ~(b | RX_SEL_MASK);
          end else if ((b & RX_SEL_MASK) == RX_SEL_MASK) begin
            state_next.remote_b = b | RX_SEL_MASK;
            result.joy_valid = 1'b1;
            result.joy_port = 1'b1;
            result.joy_level = ~(b | RX_SEL_MASK);
          end else if ((b & RX_HI_MASK) == 8'h00) begin
            state_next.remote_c = {b[3:0], 4'h0};
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/ppi_port_latch_serial_bridge.sv
// Top level of the PPI port latch serial bridge: input register, decode,
// result register and config registers. Depends on ppi_pkg, ppi_if, ppi_step.
//
// Channels: in carries one bus read, bus write or received serial byte per
// word; out returns exactly one result word per input word, in order; cfg
// writes bridge_active (index 0) or rx_decode (index 1) from bit 0 of its
// value, one write per cycle, always ready. Write config only while idle.
// A word accepted on in is held in the input register; its result then goes
// into the result register, which drives out.
// Throughput: one word per cycle while out is ready; port and latch state
// update as a word moves from the input register into the result register,
// so the next word sees it. Receiver stall: the result register holds; one
// more word waits in the input register, then in.ready drops until out drains.
// Reset (rst, synchronous): both stages empty, latches A/B = 0xFF, C = 0x00,
// control word 0x92, remote ports likewise, config registers cleared.
`default_nettype none
module ppi_port_latch_serial_bridge (
  input  wire        clk,
  input  wire        rst,
  ppi_in_if.sink     in,
  ppi_out_if.source  out,
  ppi_cfg_if.sink    cfg
);
  import ppi_pkg::*;

  logic      s1_valid;
  in_word_t  s1_word;
  logic      o_valid;
  out_word_t o_word;
  state_t    state;
  state_t    state_next;
  out_word_t result;
  cfg_t      cfg_reg;
  logic      s1_adv;
  logic      in_acc;

  assign s1_adv = s1_valid && (!o_valid || out.ready);
  assign in.ready = !s1_valid || s1_adv;
  assign in_acc = in.valid && in.ready;
  assign out.valid = o_valid;
  assign out.data = o_word;
  assign cfg.ready = 1'b1;

  ppi_step u_step (
    .cfg        (cfg_reg),
    .state      (state),
    .word       (s1_word),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      o_valid <= 1'b0;
      state <= STATE_RESET;
      cfg_reg <= '0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.data.index)
          CFG_BRIDGE_ACTIVE: cfg_reg.bridge_active <= cfg.data.value[0];
          CFG_RX_DECODE:     cfg_reg.rx_decode <= cfg.data.value[0];
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        state <= state_next;
        o_valid <= 1'b1;
      end else if (out.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_word <= in.data;
    end
    if (s1_adv) begin
      o_word <= result;
    end
  end

  a_tx_needs_bridge: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_word.tx_valid |-> cfg_reg.bridge_active)
    else $error("serial byte sent while bridge inactive");

  a_joy_needs_notify: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_word.joy_valid |-> cfg_reg.rx_decode)
    else $error("joystick update outside notify mode");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !in.ready |-> s1_valid && o_valid && !out.ready)
    else $error("input stalled with room available");

  a_last_cmd_form: assert property (@(posedge clk) disable iff (rst)
    !state.last_bit_command[7] || state.last_bit_command == BYTE_ONES)
    else $error("stored bit command has bit 7 set");

endmodule
`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for ppi_port_latch_serial_bridge: a directed script, then random
// phases, each word checked against a fixed expected word or a behavioral
// port/bridge predictor. Depends on ppi_pkg, ppi_if and the RTL of the block.
module testbench;
  import ppi_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
  localparam int N_PHASES = 8;
  localparam int PHASE_WORDS = 80;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam out_word_t NO_RESULT = '0;
  localparam out_word_t END_3F = '{end_mark_seen: 1'b1, end_mark_byte: 8'h3F, default: '0};

  typedef struct {
    bit        is_cfg;
    cfg_word_t cw;
    in_word_t  w;
    bit        has;
    out_word_t res;
  } row_t;

  typedef struct {
    bit        has;
    out_word_t res;
  } typed_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sink_ready = 1'b0;
  logic hold_off = 1'b0;
  logic no_gaps = 1'b0;

  ppi_in_if  in_ch ();
  ppi_out_if out_ch ();
  ppi_cfg_if cfg_ch ();

  assign out_ch.ready = sink_ready;

  ppi_port_latch_serial_bridge u_top (
    .clk (clk),
    .rst (rst),
    .in  (in_ch),
    .out (out_ch),
    .cfg (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  state_t    ports = STATE_RESET;
  cfg_t      regs = '0;
  out_word_t pending_results[$];
  typed_t    typed_results[$];
  row_t      script[$];
  int        n_words_in = 0;
  int        errors = 0;
  int        stall_left = 0;
  out_word_t predicted;
  typed_t    typed;
  out_word_t want;

  function automatic out_word_t ppi_respond(in_word_t w);
    out_word_t  r;
    logic [7:0] d;
    logic [7:0] b;
    logic [7:0] tx;
    logic [7:0] mask;
    logic       send;
    r = '0;
    d = w.bus_data;
    b = w.rx_byte;
    tx = '0;
    case (w.mode)
      MODE_READ: begin
        if (!w.bus_addr[0]) begin
          r.read_data = BYTE_ONES;
        end else begin
          case (w.bus_addr[2:1])
            SEL_PORT_A: r.read_data = regs.bridge_active ? ports.remote_a : ports.latch_a;
            SEL_PORT_B: r.read_data = regs.bridge_active ? ports.remote_b : ports.latch_b;
            SEL_PORT_C: r.read_data = regs.bridge_active ?
                                      (ports.remote_c | (ports.latch_c & TX_BIT_MASK)) :
                                      ports.latch_c;
            default:    r.read_data = BYTE_ONES;
          endcase
        end
      end
      MODE_WRITE: begin
        if (w.bus_addr[0]) begin
          send = regs.bridge_active;
          case (w.bus_addr[2:1])
            SEL_PORT_A: begin
              tx = (d & TX_DATA_MASK) | TX_TAG_A;
              ports.latch_a = d;
            end
            SEL_PORT_B: begin
              tx = (d & TX_DATA_MASK) | TX_TAG_B;
              ports.latch_b = d;
            end
            SEL_PORT_C: begin
              tx = d >> 4;
              ports.latch_c = d;
            end
            default: begin
              if (d[7]) begin
                tx = ((d & TX_CW_MASK) >> 1) | (d & TX_CW_LOW) | TX_TAG_CW;
                ports.control_word = d;
              end else begin
                mask = 8'h01 << d[3:1];
                if (send) begin
                  // repeated bit command: latch still updated, nothing sent
                  if (d == ports.last_bit_command) begin
                    send = 1'b0;
                  end else begin
                    ports.last_bit_command = d;
                    tx = (d & TX_BIT_MASK) | TX_TAG_BIT;
                  end
                end
                if (d[0]) ports.latch_c = ports.latch_c | mask;
                else ports.latch_c = ports.latch_c & ~mask;
              end
            end
          endcase
          if (send) begin
            r.tx_valid = 1'b1;
            r.tx_byte = tx;
          end
        end
      end
      MODE_RX: begin
        if ((b & RX_HI_MASK) == RX_END_MARK) begin
          r.end_mark_seen = 1'b1;
          r.end_mark_byte = b;
        end
        if (regs.rx_decode) begin
          if ((b & RX_SEL_MASK) == TX_TAG_A) begin
            ports.remote_a = b | RX_SEL_MASK;
            r.joy_valid = 1'b1;
            r.joy_port = 1'b0;
            r.joy_level = ~ports.remote_a;
          end else if ((b & RX_SEL_MASK) == RX_SEL_MASK) begin
            ports.remote_b = b | RX_SEL_MASK;
            r.joy_valid = 1'b1;
            r.joy_port = 1'b1;
            r.joy_level = ~ports.remote_b;
          end else if ((b & RX_HI_MASK) == 8'h00) begin
            ports.remote_c = b << 4;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic row_t bus_row(logic [1:0] m, logic [2:0] a, logic [7:0] d,
                                   logic [7:0] rx, bit has = 1'b0,
                                   out_word_t res = '0);
    row_t r;
    r.is_cfg = 1'b0;
    r.cw = '0;
    r.w = '{mode: m, bus_addr: a, bus_data: d, rx_byte: rx};
    r.has = has;
    r.res = res;
    return r;
  endfunction

  function automatic row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    row_t r;
    r.is_cfg = 1'b1;
    r.cw = '{index: idx, value: v};
    r.w = '0;
    r.has = 1'b0;
    r.res = '0;
    return r;
  endfunction

  function automatic out_word_t read_as(logic [7:0] v);
    out_word_t r;
    r = '0;
    r.read_data = v;
    return r;
  endfunction

  task automatic send_word(in_word_t w, bit has, out_word_t res);
    int     gap;
    typed_t t;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    t.has = has;
    t.res = res;
    typed_results.push_back(t);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // registers change only with the pipeline drained
  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (3) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= '{index: idx, value: v};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.data.index)
        CFG_BRIDGE_ACTIVE: regs.bridge_active = cfg_ch.data.value[0];
        CFG_RX_DECODE:     regs.rx_decode = cfg_ch.data.value[0];
        default: ;
      endcase
    end
    if (!rst && in_ch.valid && in_ch.ready) begin
      predicted = ppi_respond(in_ch.data);
      typed = typed_results.pop_front();
      pending_results.push_back(typed.has ? typed.res : predicted);
      n_words_in++;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      sink_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word at %0t", $realtime);
        end else begin
          want = pending_results.pop_front();
          if ((out_ch.data.read_data !== want.read_data) ||
              (out_ch.data.tx_valid !== want.tx_valid) ||
              (out_ch.data.tx_byte !== want.tx_byte) ||
              (out_ch.data.joy_valid !== want.joy_valid) ||
              (out_ch.data.joy_port !== want.joy_port) ||
              (out_ch.data.joy_level !== want.joy_level) ||
              (out_ch.data.end_mark_seen !== want.end_mark_seen) ||
              (out_ch.data.end_mark_byte !== want.end_mark_byte)) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch at %0t: exp rd=%h tx=%b/%h joy=%b/%b/%h end=%b/%h",
                       $realtime, want.read_data, want.tx_valid, want.tx_byte,
                       want.joy_valid, want.joy_port, want.joy_level,
                       want.end_mark_seen, want.end_mark_byte);
              $display("               got rd=%h tx=%b/%h joy=%b/%b/%h end=%b/%h",
                       out_ch.data.read_data, out_ch.data.tx_valid, out_ch.data.tx_byte,
                       out_ch.data.joy_valid, out_ch.data.joy_port, out_ch.data.joy_level,
                       out_ch.data.end_mark_seen, out_ch.data.end_mark_byte);
            end
          end
        end
        stall_left = no_gaps ? 0 : $urandom_range(0, 9);
      end
      if (hold_off) begin
        sink_ready <= 1'b0;
      end else if (stall_left != 0) begin
        sink_ready <= 1'b0;
        stall_left--;
      end else begin
        sink_ready <= 1'b1;
      end
    end
  end

  // long receiver hold-off so both pipeline stages fill and in.ready drops
  initial begin
    while (n_words_in < 120) @(negedge clk);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) idle = 0;
      else idle++;
    end
    $display("ppi_port_latch_serial_bridge verification failed");
    $finish;
  end

  initial begin
    in_word_t   w;
    int         pick;
    logic [7:0] last_cmd;
    logic       bridge_sel;
    logic       notify_sel;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    last_cmd = 8'h01;

    // reset values, bridge off
    script.push_back(bus_row(MODE_READ, {SEL_PORT_A, 1'b1}, 8'h00, 8'h00, 1, read_as(8'hFF)));
    script.push_back(bus_row(MODE_READ, {SEL_PORT_B, 1'b1}, 8'h00, 8'h00, 1, read_as(8'hFF)));
    script.push_back(bus_row(MODE_READ, {SEL_PORT_C, 1'b1}, 8'h00, 8'h00, 1, read_as(8'h00)));
    script.push_back(bus_row(MODE_READ, {SEL_CONTROL, 1'b1}, 8'h00, 8'h00, 1, read_as(8'hFF)));
    script.push_back(bus_row(MODE_READ, {SEL_PORT_A, 1'b0}, 8'hFF, 8'hFF, 1, read_as(8'hFF)));
    script.push_back(bus_row(MODE_WRITE, {SEL_PORT_A, 1'b1}, 8'hFF, 8'h00, 1, NO_RESULT));
    script.push_back(bus_row(MODE_WRITE, {SEL_PORT_C, 1'b0}, 8'h55, 8'h00, 1, NO_RESULT));
    script.push_back(bus_row(MODE_WRITE, {SEL_CONTROL, 1'b1}, 8'h0F, 8'h00, 1, NO_RESULT));
    script.push_back(bus_row(MODE_READ, {SEL_PORT_C, 1'b1}, 8'h00, 8'h00));
    script.push_back(bus_row(MODE_UNUSED, 3'h7, 8'hFF, 8'hFF, 1, NO_RESULT));
    script.push_back(bus_row(MODE_RX, {SEL_PORT_A, 1'b1}, 8'h00, 8'h3F, 1, END_3F));
    // bridge on, notify on
    script.push_back(reg_row(CFG_BRIDGE_ACTIVE, 8'hFF));
    script.push_back(reg_row(CFG_RX_DECODE, 8'h01));
    script.push_back(bus_row(MODE_WRITE, {SEL_PORT_A, 1'b1}, 8'h00, 8'h00));
    script.push_back(bus_row(MODE_WRITE, {SEL_PORT_B, 1'b1}, 8'hFF, 8'h00));
    script.push_back(bus_row(MODE_WRITE, {SEL_PORT_C, 1'b1}, 8'hF0, 8'h00));
    script.push_back(bus_row(MODE_WRITE, {SEL_CONTROL, 1'b1}, 8'hFF, 8'h00));
    script.push_back(bus_row(MODE_WRITE, {SEL_CONTROL, 1'b1}, 8'h01, 8'h00));
    script.push_back(bus_row(MODE_WRITE, {SEL_CONTROL, 1'b1}, 8'h01, 8'h00));
    script.push_back(bus_row(MODE_WRITE, {SEL_CONTROL, 1'b1}, 8'h00, 8'h00));
    script.push_back(bus_row(MODE_RX, 3'h0, 8'h00, 8'h80));
    script.push_back(bus_row(MODE_RX, 3'h0, 8'h00, 8'h9F));
    script.push_back(bus_row(MODE_RX, 3'h0, 8'h00, 8'h0A));
    script.push_back(bus_row(MODE_RX, 3'h0, 8'h00, 8'h35));
    script.push_back(bus_row(MODE_READ, {SEL_PORT_A, 1'b1}, 8'h00, 8'h00));
    script.push_back(bus_row(MODE_READ, {SEL_PORT_B, 1'b1}, 8'h00, 8'h00));
    script.push_back(bus_row(MODE_READ, {SEL_PORT_C, 1'b1}, 8'h00, 8'h00));
    // unmapped indexes, then both registers back off
    script.push_back(reg_row(CFG_SPARE_2, 8'hFF));
    script.push_back(reg_row(CFG_SPARE_3, 8'hFF));
    script.push_back(reg_row(CFG_BRIDGE_ACTIVE, 8'hFE));
    script.push_back(reg_row(CFG_RX_DECODE, 8'h00));
    script.push_back(bus_row(MODE_READ, {SEL_PORT_A, 1'b1}, 8'h00, 8'h00));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].is_cfg) set_reg(script[i].cw.index, script[i].cw.value);
      else send_word(script[i].w, script[i].has, script[i].res);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      bridge_sel = (p < 4) ? p[0] : 1'($urandom);
      notify_sel = (p < 4) ? p[1] : 1'($urandom);
      set_reg(CFG_BRIDGE_ACTIVE, {7'($urandom), bridge_sel});
      set_reg(CFG_RX_DECODE, {7'($urandom), notify_sel});
      no_gaps <= (p == 2) || (p == 5);
      repeat (PHASE_WORDS) begin
        w.bus_data = 8'($urandom);
        w.rx_byte = 8'($urandom);
        pick = $urandom_range(0, 99);
        w.mode = (pick < 25) ? MODE_READ : (pick < 60) ? MODE_WRITE :
                 (pick < 95) ? MODE_RX : MODE_UNUSED;
        w.bus_addr = {2'($urandom), ($urandom_range(0, 9) != 0)};
        if (w.mode == MODE_WRITE && w.bus_addr[2:1] == SEL_CONTROL) begin
          if ($urandom_range(0, 2) == 0) w.bus_data = last_cmd;
          else if ($urandom_range(0, 1) == 1) w.bus_data[7] = 1'b0;
          if (!w.bus_data[7]) last_cmd = w.bus_data;
        end
        if (w.mode == MODE_RX) begin
          case ($urandom_range(0, 4))
            0: begin
              w.rx_byte[7] = 1'b1;
              w.rx_byte[4] = 1'b0;
            end
            1: begin
              w.rx_byte[7] = 1'b1;
              w.rx_byte[4] = 1'b1;
            end
            2: w.rx_byte[7:4] = 4'h0;
            3: w.rx_byte[7:4] = RX_END_MARK[7:4];
            default: ;
          endcase
        end
        send_word(w, 1'b0, NO_RESULT);
      end
    end

    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("ppi_port_latch_serial_bridge verification clean");
    end else begin
      $display("ppi_port_latch_serial_bridge verification failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/ppi_pkg.sv
rtl/ppi_if.sv
rtl/ppi_step.sv
rtl/ppi_port_latch_serial_bridge.sv
tb/sv/testbench.sv
